/* sv/rqps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ready queue policy select: shared package
// Sizes, operation and status codes, and the types passed along the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package rqps_pkg;

  // Queue and thread table sizes.
  localparam int QUEUE_DEPTH = 64;
  localparam int NUM_THREADS = 16;

  // Field widths.
  localparam int THREAD_W = 4;
  localparam int BURST_W  = 16;
  localparam int LEN_W    = 16;
  localparam int RT_W     = 32;
  localparam int OCC_W    = 7;
  localparam int KEY_W    = 32;

  // Derived widths.
  localparam int IDX_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int THR_IDX_W = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;

  // Operation codes.
  typedef enum logic [1:0] {
    FN_PUSH = 2'd0,
    FN_POP  = 2'd1,
    FN_SET  = 2'd2,
    FN_NOP  = 2'd3
  } func_e;

  // Selection policies.
  typedef enum logic [1:0] {
    FCFS     = 2'd0,
    SJF      = 2'd1,
    PRIO     = 2'd2,
    VRUNTIME = 2'd3
  } policy_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_POPPED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // One queued burst, with a copy of its thread's virtual runtime.
  typedef struct packed {
    logic [THREAD_W-1:0] thread;
    logic [BURST_W-1:0]  burst;
    logic [LEN_W-1:0]    len;
    logic [RT_W-1:0]     vrt;
  } entry_t;

  // Best candidate so far, handed from a cell to its right neighbor.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
    entry_t           ent;
  } best_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    policy_e             policy;
    logic [CNT_W-1:0]    count;
    logic                push_en;
    entry_t              push_entry;
    logic                pop_en;
    logic [IDX_W-1:0]    pop_slot;
    logic                set_en;
    logic [THREAD_W-1:0] set_thread;
    logic [RT_W-1:0]     set_value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* sv/rqps_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ready queue policy select: channel interfaces
// Valid/ready channels for operation words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

// Operation word channel.
interface rqps_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    func;
  logic [rqps_pkg::THREAD_W-1:0] thread_num;
  logic [rqps_pkg::BURST_W-1:0]  burst_num;
  logic [rqps_pkg::LEN_W-1:0]    burst_length;
  logic [rqps_pkg::RT_W-1:0]     runtime_value;

  modport source (
    output valid, func, thread_num, burst_num, burst_length, runtime_value,
    input  ready
  );
  modport sink (
    input  valid, func, thread_num, burst_num, burst_length, runtime_value,
    output ready
  );
endinterface

// Result word channel.
interface rqps_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [rqps_pkg::THREAD_W-1:0] out_thread;
  logic [rqps_pkg::BURST_W-1:0]  out_burst;
  logic [rqps_pkg::LEN_W-1:0]    out_length;
  logic [rqps_pkg::OCC_W-1:0]    occupancy;

  modport source (
    output valid, status, out_thread, out_burst, out_length, occupancy,
    input  ready
  );
  modport sink (
    input  valid, status, out_thread, out_burst, out_length, occupancy,
    output ready
  );
endinterface

`default_nettype wire

/* sv/ready_queue_policy_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ready queue policy select: top level
// Ordered ready queue of CPU bursts with FCFS, SJF, priority and vruntime pops.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake       Word
//  in_i      in    valid/ready     func, thread_num, burst_num, burst_length,
//                                  runtime_value
//  out_o     out   valid/ready     status, out_thread, out_burst, out_length,
//                                  occupancy
//  cfg       in    cfg_we_i        policy (2 bits)
//
//  A push, a set, an unused code or a pop on an empty queue moves from
//  acceptance to S_DONE and is answered once the result register is free.
//  A pop on a non-empty queue passes through S_SCAN first: the best
//  candidate moves one cell per cycle along the row of QUEUE_DEPTH cells.
//  One operation is in flight at a time; the result register holds a word
//  while out_o is stalled, and the next word is accepted meanwhile.
//  Reset clears the queue count, the policy and the runtime valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module ready_queue_policy_select (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  rqps_in_if.sink    in_i,
  rqps_out_if.source out_o
);

  localparam int Depth = rqps_pkg::QUEUE_DEPTH;
  localparam int NThr  = rqps_pkg::NUM_THREADS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e                          state_q;
  logic [rqps_pkg::CNT_W-1:0]      count_q, count_d;
  logic [rqps_pkg::IDX_W-1:0]      scan_cnt_q;
  rqps_pkg::policy_e               policy_q;
  logic [NThr-1:0]                 rt_vld_q;
  logic [rqps_pkg::RT_W-1:0]       rt_mem [NThr];
  logic [rqps_pkg::RT_W-1:0]       rt_rd_q;
  logic                            rt_rd_vld_q;

  // Operation held while it is worked on.
  rqps_pkg::func_e                 op_func_q;
  rqps_pkg::status_e               op_status_q;
  logic [rqps_pkg::THREAD_W-1:0]   op_thread_q;
  logic [rqps_pkg::BURST_W-1:0]    op_burst_q;
  logic [rqps_pkg::LEN_W-1:0]      op_len_q;
  logic [rqps_pkg::RT_W-1:0]       op_rv_q;

  // Result register.
  logic                            out_valid_q;
  rqps_pkg::status_e               out_status_q;
  logic [rqps_pkg::THREAD_W-1:0]   out_thread_q;
  logic [rqps_pkg::BURST_W-1:0]    out_burst_q;
  logic [rqps_pkg::LEN_W-1:0]      out_length_q;
  logic [rqps_pkg::OCC_W-1:0]      out_occ_q;

  logic                            in_acc;
  logic                            commit;
  logic                            in_thr_ok;
  logic                            op_thr_ok;
  logic [rqps_pkg::THR_IDX_W-1:0]  in_thr_idx;
  logic [rqps_pkg::THR_IDX_W-1:0]  op_thr_idx;
  rqps_pkg::cell_ctrl_t            ctrl;
  rqps_pkg::entry_t                ent [Depth];
  rqps_pkg::best_t                 best [Depth];
  rqps_pkg::best_t                 winner;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign commit     = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  assign in_thr_ok  = 32'(in_i.thread_num) < 32'(NThr);
  assign op_thr_ok  = 32'(op_thread_q) < 32'(NThr);
  assign in_thr_idx = rqps_pkg::THR_IDX_W'(in_i.thread_num);
  assign op_thr_idx = rqps_pkg::THR_IDX_W'(op_thread_q);

  assign winner = best[Depth-1];

  // Broadcast control for the cell row; updates land on the commit cycle.
  always_comb begin
    ctrl.policy     = policy_q;
    ctrl.count      = count_q;
    ctrl.push_en    = commit && (op_func_q == rqps_pkg::FN_PUSH)
                      && (op_status_q == rqps_pkg::ST_OK);
    ctrl.push_entry = '{thread: op_thread_q, burst: op_burst_q, len: op_len_q,
                        vrt: rt_rd_vld_q ? rt_rd_q : '0};
    ctrl.pop_en     = commit && (op_status_q == rqps_pkg::ST_POPPED);
    ctrl.pop_slot   = winner.idx;
    ctrl.set_en     = commit && (op_func_q == rqps_pkg::FN_SET) && op_thr_ok;
    ctrl.set_thread = op_thread_q;
    ctrl.set_value  = op_rv_q;
  end

  // Row of queue cells.
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    rqps_pkg::entry_t next_ent;
    rqps_pkg::best_t  prev_best;
    if (i == Depth - 1) begin : g_last
      assign next_ent = '0;
    end else begin : g_mid
      assign next_ent = ent[i+1];
    end
    if (i == 0) begin : g_first
      assign prev_best = '0;
    end else begin : g_rest
      assign prev_best = best[i-1];
    end
    rqps_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (rqps_pkg::IDX_W'(i)),
      .ctrl_i (ctrl),
      .next_i (next_ent),
      .prev_i (prev_best),
      .ent_o  (ent[i]),
      .best_o (best[i])
    );
  end

  // Queue count after the committed operation.
  always_comb begin
    count_d = count_q;
    if (ctrl.push_en) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.pop_en) begin
      count_d = count_q - 1'b1;
    end
  end

  // Runtime table: written on a set, read when any operation word is accepted.
  always_ff @(posedge clk_i) begin
    if (ctrl.set_en) begin
      rt_mem[op_thr_idx] <= op_rv_q;
    end
    if (in_acc) begin
      rt_rd_q <= rt_mem[in_thr_idx];
    end
  end

  // Runtime valid bits and their registered read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_vld_q    <= '0;
      rt_rd_vld_q <= 1'b0;
    end else begin
      if (ctrl.set_en) begin
        rt_vld_q[op_thr_idx] <= 1'b1;
      end
      if (in_acc) begin
        rt_rd_vld_q <= in_thr_ok && rt_vld_q[in_thr_idx];
      end
    end
  end

  // Policy register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= rqps_pkg::FCFS;
    end else if (cfg_we_i) begin
      policy_q <= rqps_pkg::policy_e'(cfg_wdata_i);
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && !commit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            op_func_q   <= rqps_pkg::func_e'(in_i.func);
            op_thread_q <= in_i.thread_num;
            op_burst_q  <= in_i.burst_num;
            op_len_q    <= in_i.burst_length;
            op_rv_q     <= in_i.runtime_value;
            case (rqps_pkg::func_e'(in_i.func))
              rqps_pkg::FN_PUSH: begin
                op_status_q <= (32'(count_q) >= 32'(Depth)) ? rqps_pkg::ST_FULL
                                                             : rqps_pkg::ST_OK;
                state_q     <= S_DONE;
              end
              rqps_pkg::FN_POP: begin
                if (count_q == '0) begin
                  op_status_q <= rqps_pkg::ST_EMPTY;
                  state_q     <= S_DONE;
                end else begin
                  op_status_q <= rqps_pkg::ST_POPPED;
                  scan_cnt_q  <= rqps_pkg::IDX_W'(Depth - 1);
                  state_q     <= S_SCAN;
                end
              end
              default: begin
                op_status_q <= rqps_pkg::ST_OK;
                state_q     <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_cnt_q == '0) begin
            state_q <= S_DONE;
          end else begin
            scan_cnt_q <= scan_cnt_q - 1'b1;
          end
        end
        S_DONE: begin
          if (commit) begin
            count_q      <= count_d;
            out_valid_q  <= 1'b1;
            out_status_q <= op_status_q;
            out_occ_q    <= rqps_pkg::OCC_W'(count_d);
            if (op_status_q == rqps_pkg::ST_POPPED) begin
              out_thread_q <= winner.ent.thread;
              out_burst_q  <= winner.ent.burst;
              out_length_q <= winner.ent.len;
            end else begin
              out_thread_q <= '0;
              out_burst_q  <= '0;
              out_length_q <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.out_thread = out_thread_q;
  assign out_o.out_burst  = out_burst_q;
  assign out_o.out_length = out_length_q;
  assign out_o.occupancy  = out_occ_q;

  // The queue never holds more bursts than it has cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(Depth))
    else $error("queue count exceeds depth");

  // A scan only runs over a non-empty queue.
  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (count_q != '0))
    else $error("scan on empty queue");

  // A committed pop removes exactly one burst.
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.pop_en |=> (count_q == rqps_pkg::CNT_W'($past(count_q) - 1'b1)))
    else $error("pop did not remove one burst");

  // An empty report always carries zero occupancy.
  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == rqps_pkg::ST_EMPTY)) |-> (out_occ_q == '0))
    else $error("empty status with nonzero occupancy");

endmodule

`default_nettype wire

/* sv/rqps_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ready queue policy select: queue cell
// Holds one queue slot and passes the running best candidate to the right.
// ----------------------------------------------------------------------------
`default_nettype none

module rqps_cell (
  input  logic                       clk_i,
  input  logic [rqps_pkg::IDX_W-1:0] idx_i,
  input  rqps_pkg::cell_ctrl_t       ctrl_i,
  input  rqps_pkg::entry_t           next_i,
  input  rqps_pkg::best_t            prev_i,
  output rqps_pkg::entry_t           ent_o,
  output rqps_pkg::best_t            best_o
);

  rqps_pkg::entry_t          ent_q, ent_d;
  rqps_pkg::best_t           best_q, best_d;
  rqps_pkg::best_t           own;
  logic [rqps_pkg::KEY_W-1:0] key;
  logic                      occupied;

  assign occupied = rqps_pkg::CNT_W'(idx_i) < ctrl_i.count;

  // Selection key of this slot; a smaller key wins.
  always_comb begin
    case (ctrl_i.policy)
      rqps_pkg::SJF:      key = rqps_pkg::KEY_W'(ent_q.len);
      rqps_pkg::PRIO:     key = rqps_pkg::KEY_W'(ent_q.thread);
      rqps_pkg::VRUNTIME: key = rqps_pkg::KEY_W'(ent_q.vrt);
      default:            key = '0;
    endcase
  end

  assign own = '{key: key, idx: idx_i, ent: ent_q};

  // Compare with the left neighbor; the older slot keeps a tie.
  always_comb begin
    if (!occupied) begin
      best_d = prev_i;
    end else if (idx_i == '0) begin
      best_d = own;
    end else if (key < prev_i.key) begin
      best_d = own;
    end else begin
      best_d = prev_i;
    end
  end

  // Slot update: append, close the gap after a removal, or refresh runtime.
  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.push_en && (rqps_pkg::CNT_W'(idx_i) == ctrl_i.count)) begin
      ent_d = ctrl_i.push_entry;
    end
    if (ctrl_i.pop_en && (idx_i >= ctrl_i.pop_slot)) begin
      ent_d = next_i;
    end
    if (ctrl_i.set_en && (ent_q.thread == ctrl_i.set_thread)) begin
      ent_d.vrt = ctrl_i.set_value;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q  <= ent_d;
    best_q <= best_d;
  end

  assign ent_o  = ent_q;
  assign best_o = best_q;

endmodule

`default_nettype wire

/* verif/ready_queue_policy_select_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ready queue policy select: testbench
// Drives push, pop, set and unused operation words with bursty random timing,
// predicts every result word from its own model of the ready queue, and
// checks the words that come out in order.
// ----------------------------------------------------------------------------

module ready_queue_policy_select_tb;

  localparam int THREAD_W    = rqps_pkg::THREAD_W;
  localparam int BURST_W     = rqps_pkg::BURST_W;
  localparam int LEN_W       = rqps_pkg::LEN_W;
  localparam int RT_W        = rqps_pkg::RT_W;
  localparam int OCC_W       = rqps_pkg::OCC_W;
  localparam int QUEUE_DEPTH = rqps_pkg::QUEUE_DEPTH;
  localparam int NUM_THREADS = rqps_pkg::NUM_THREADS;

  localparam int CLK_HALF     = 4;
  localparam int LIMIT_CYCLES = 500000;
  localparam int PHASE_OPS    = 95;
  localparam int HOLD_CYCLES  = 400;

  // One operation word as offered on the input channel.
  typedef struct packed {
    rqps_pkg::func_e     func;
    logic [THREAD_W-1:0] thread;
    logic [BURST_W-1:0]  burst;
    logic [LEN_W-1:0]    len;
    logic [RT_W-1:0]     rv;
  } op_t;

  // One result word as seen on the output channel.
  typedef struct packed {
    rqps_pkg::status_e   status;
    logic [THREAD_W-1:0] thread;
    logic [BURST_W-1:0]  burst;
    logic [LEN_W-1:0]    len;
    logic [OCC_W-1:0]    occ;
  } result_t;

  // A burst held in the predicted ready queue.
  typedef struct packed {
    logic [THREAD_W-1:0] thread;
    logic [BURST_W-1:0]  burst;
    logic [LEN_W-1:0]    len;
  } burst_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_wdata_i;

  rqps_in_if  in_ch ();
  rqps_out_if out_ch ();

  ready_queue_policy_select dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // Predicted block state.
  burst_t            ready_q[$];
  logic [RT_W-1:0]   vrt_tab [NUM_THREADS] = '{default: '0};
  rqps_pkg::policy_e cur_policy = rqps_pkg::FCFS;

  // Operation words still to send and result words still to come.
  op_t     pending_ops[$];
  result_t expected_words[$];

  // Queue depth as the generator sees it, to steer fill and drain sequences.
  int gen_count = 0;

  int errors     = 0;
  int n_ops      = 0;
  int n_settings = 0;
  int n_status [4] = '{default: 0};
  int cycle_cnt  = 0;

  // Driver state.
  bit  offering   = 1'b0;
  op_t cur_op     = '0;
  int  gap_left   = 0;
  int  burst_left = 0;

  // Receiver state.
  bit rx_choppy = 1'b0;
  int rx_mode_left = 0;
  int rx_hold_left = 0;
  int rx_words = 0;
  int rx_next_hold = 250;

  // Selection key of queue slot i under the current policy; smaller wins.
  function automatic logic [31:0] sel_key(int i);
    case (cur_policy)
      rqps_pkg::SJF:      return 32'(ready_q[i].len);
      rqps_pkg::PRIO:     return 32'(ready_q[i].thread);
      rqps_pkg::VRUNTIME: return (ready_q[i].thread < NUM_THREADS)
                                 ? vrt_tab[ready_q[i].thread] : '0;
      default:            return 32'(i);
    endcase
  endfunction

  // Applies one accepted operation to the predicted state and returns its result.
  function automatic result_t apply_op(op_t op);
    result_t     r;
    int          pick;
    logic [31:0] best_key;
    logic [31:0] k;
    r = '0;
    r.status = rqps_pkg::ST_OK;
    case (op.func)
      rqps_pkg::FN_PUSH: begin
        if (ready_q.size() >= QUEUE_DEPTH) begin
          r.status = rqps_pkg::ST_FULL;
        end else begin
          ready_q.push_back('{thread: op.thread, burst: op.burst, len: op.len});
        end
      end
      rqps_pkg::FN_POP: begin
        if (ready_q.size() == 0) begin
          r.status = rqps_pkg::ST_EMPTY;
        end else begin
          // Strict compare keeps the oldest entry on a tie.
          pick = 0;
          best_key = sel_key(0);
          for (int i = 1; i < ready_q.size(); i++) begin
            k = sel_key(i);
            if (k < best_key) begin
              best_key = k;
              pick = i;
            end
          end
          r.status = rqps_pkg::ST_POPPED;
          r.thread = ready_q[pick].thread;
          r.burst  = ready_q[pick].burst;
          r.len    = ready_q[pick].len;
          ready_q.delete(pick);
        end
      end
      rqps_pkg::FN_SET: begin
        if (op.thread < NUM_THREADS) begin
          vrt_tab[op.thread] = op.rv;
        end
      end
      default: ;
    endcase
    r.occ = OCC_W'(ready_q.size());
    return r;
  endfunction

  // Queues one operation word and tracks the depth it leads to.
  function automatic void add_op(rqps_pkg::func_e f, logic [THREAD_W-1:0] thr,
                                 logic [BURST_W-1:0] bid, logic [LEN_W-1:0] len,
                                 logic [RT_W-1:0] rv);
    pending_ops.push_back('{func: f, thread: thr, burst: bid, len: len, rv: rv});
    n_ops++;
    if (f == rqps_pkg::FN_PUSH && gen_count < QUEUE_DEPTH) begin
      gen_count++;
    end else if (f == rqps_pkg::FN_POP && gen_count > 0) begin
      gen_count--;
    end
  endfunction

  // Queues one operation word with random fields, biased toward ties and extremes.
  function automatic void add_random(rqps_pkg::func_e f);
    logic [LEN_W-1:0] len;
    logic [RT_W-1:0]  rv;
    case ($urandom_range(0, 3))
      0:       len = LEN_W'($urandom_range(0, 7));
      1:       len = {LEN_W{1'b1}} - LEN_W'($urandom_range(0, 7));
      default: len = LEN_W'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 3))
      0:       rv = RT_W'($urandom_range(0, 3));
      1:       rv = {RT_W{1'b1}};
      default: rv = $urandom;
    endcase
    add_op(f, THREAD_W'($urandom_range(0, 15)), BURST_W'($urandom_range(0, 65535)), len, rv);
  endfunction

  // Waits until every word has been sent and every expected result has come.
  task automatic wait_idle();
    while (pending_ops.size() != 0 || offering || expected_words.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Writes the policy register while the block is idle.
  task automatic write_policy(rqps_pkg::policy_e p);
    wait_idle();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= p;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_policy = p;
    n_settings++;
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("%0t: run limit of %0d cycles reached", $time, LIMIT_CYCLES);
      $display("[ready_queue_policy_select] ERROR");
      $finish;
    end
  end

  // Driver: sends pending words in bursts with random gaps between them.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid         <= 1'b0;
      in_ch.func          <= '0;
      in_ch.thread_num    <= '0;
      in_ch.burst_num     <= '0;
      in_ch.burst_length  <= '0;
      in_ch.runtime_value <= '0;
      offering   = 1'b0;
      gap_left   = 0;
      burst_left = 0;
    end else begin
      if (offering && in_ch.ready) begin
        expected_words.push_back(apply_op(cur_op));
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() > 0) begin
          cur_op = pending_ops.pop_front();
          offering = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
      in_ch.valid         <= offering;
      in_ch.func          <= cur_op.func;
      in_ch.thread_num    <= cur_op.thread;
      in_ch.burst_num     <= cur_op.burst;
      in_ch.burst_length  <= cur_op.len;
      in_ch.runtime_value <= cur_op.rv;
    end
  end

  // Receiver: free-running and choppy stretches, plus long hold-offs that back
  // the block up while the driver keeps offering.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      rx_choppy    = 1'b0;
      rx_mode_left = 0;
      rx_hold_left = 0;
      rx_words     = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        rx_words++;
      end
      if (rx_words >= rx_next_hold) begin
        rx_hold_left = HOLD_CYCLES;
        rx_next_hold += HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_choppy    = ($urandom_range(0, 2) != 0);
          rx_mode_left = $urandom_range(10, 60);
        end
        rx_mode_left--;
        out_ch.ready <= rx_choppy ? ($urandom_range(0, 2) != 0) : 1'b1;
      end
    end
  end

  // Monitor: checks each result word against the oldest prediction.
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.status = rqps_pkg::status_e'(out_ch.status);
      got.thread = out_ch.out_thread;
      got.burst  = out_ch.out_burst;
      got.len    = out_ch.out_length;
      got.occ    = out_ch.occupancy;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word: status %0d thread %0d burst %h len %h occ %0d",
                 $time, got.status, got.thread, got.burst, got.len, got.occ);
        errors++;
      end else begin
        want = expected_words.pop_front();
        n_status[want.status]++;
        if (got !== want) begin
          $display("%0t: mismatch: expected status %0d thread %0d burst %h len %h occ %0d",
                   $time, want.status, want.thread, want.burst, want.len, want.occ);
          $display("%0t:           actual   status %0d thread %0d burst %h len %h occ %0d",
                   $time, got.status, got.thread, got.burst, got.len, got.occ);
          errors++;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    rqps_pkg::policy_e phase_pol [8] = '{rqps_pkg::SJF, rqps_pkg::PRIO, rqps_pkg::FCFS,
                                         rqps_pkg::VRUNTIME, rqps_pkg::PRIO, rqps_pkg::SJF,
                                         rqps_pkg::VRUNTIME, rqps_pkg::FCFS};
    int                n;
    int                seg;
    int                r;
    rqps_pkg::func_e   f;

    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset policy: empty pop, unused code, extremes.
    add_op(rqps_pkg::FN_POP,  4'd0,  16'h0000, 16'h0000, 32'h0000_0000);
    add_op(rqps_pkg::FN_NOP,  4'd15, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    add_op(rqps_pkg::FN_SET,  4'd15, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
    add_op(rqps_pkg::FN_SET,  4'd0,  16'hFFFF, 16'hFFFF, 32'h0000_0000);
    add_op(rqps_pkg::FN_SET,  4'd5,  16'h0000, 16'h0000, 32'h0000_0001);
    add_op(rqps_pkg::FN_PUSH, 4'd15, 16'hFFFF, 16'hFFFF, 32'h0000_0000);
    add_op(rqps_pkg::FN_PUSH, 4'd0,  16'h0000, 16'h0000, 32'hFFFF_FFFF);
    add_op(rqps_pkg::FN_PUSH, 4'd5,  16'h1234, 16'h0001, 32'h0000_0000);
    add_op(rqps_pkg::FN_PUSH, 4'd0,  16'hAAAA, 16'h0000, 32'h0000_0000);
    add_op(rqps_pkg::FN_PUSH, 4'd9,  16'h5555, 16'h8000, 32'h0000_0000);
    add_op(rqps_pkg::FN_POP,  4'd0,  16'h0000, 16'h0000, 32'h0000_0000);

    // Lowest vruntime, with a tie between two bursts of thread 0 and one of thread 9.
    write_policy(rqps_pkg::VRUNTIME);
    add_op(rqps_pkg::FN_POP,  4'd0,  16'h0000, 16'h0000, 32'h0000_0000);
    add_op(rqps_pkg::FN_POP,  4'd0,  16'h0000, 16'h0000, 32'h0000_0000);

    // Shortest length, then lowest thread id down to an empty queue.
    write_policy(rqps_pkg::SJF);
    add_op(rqps_pkg::FN_PUSH, 4'd3,  16'h0F0F, 16'h0000, 32'h0000_0000);
    add_op(rqps_pkg::FN_POP,  4'd0,  16'h0000, 16'h0000, 32'h0000_0000);
    write_policy(rqps_pkg::PRIO);
    add_op(rqps_pkg::FN_POP,  4'd0,  16'h0000, 16'h0000, 32'h0000_0000);
    add_op(rqps_pkg::FN_POP,  4'd0,  16'h0000, 16'h0000, 32'h0000_0000);
    add_op(rqps_pkg::FN_POP,  4'd0,  16'h0000, 16'h0000, 32'h0000_0000);

    // Random phases: fill to overflow, drain past empty, and mixed traffic.
    foreach (phase_pol[p]) begin
      write_policy(phase_pol[p]);
      n = 0;
      while (n < PHASE_OPS) begin
        seg = $urandom_range(0, 9);
        if (seg < 2) begin
          while (gen_count < QUEUE_DEPTH) begin
            add_random(rqps_pkg::FN_PUSH);
            n++;
          end
          repeat ($urandom_range(1, 2)) begin
            add_random(rqps_pkg::FN_PUSH);
            n++;
          end
        end else if (seg < 4) begin
          while (gen_count > 0) begin
            add_random(rqps_pkg::FN_POP);
            n++;
          end
          add_random(rqps_pkg::FN_POP);
          n++;
        end else begin
          repeat ($urandom_range(8, 24)) begin
            r = $urandom_range(0, 99);
            f = (r < 45) ? rqps_pkg::FN_PUSH :
                (r < 80) ? rqps_pkg::FN_POP  :
                (r < 95) ? rqps_pkg::FN_SET  : rqps_pkg::FN_NOP;
            add_random(f);
            n++;
          end
        end
      end
    end

    wait_idle();
    repeat (QUEUE_DEPTH + 8) @(posedge clk_i);

    $display("Sent %0d operation words across %0d policy settings.", n_ops, n_settings);
    $display("Results: %0d accepted, %0d popped, %0d empty, %0d full.",
             n_status[rqps_pkg::ST_OK], n_status[rqps_pkg::ST_POPPED],
             n_status[rqps_pkg::ST_EMPTY], n_status[rqps_pkg::ST_FULL]);
    if (errors == 0) begin
      $display("[ready_queue_policy_select] OK");
    end else begin
      $display("[ready_queue_policy_select] ERROR");
    end
    $finish;
  end

endmodule
